// ----- rtl/core/rans_byte_encoder_macros.svh -----
// ----------------------------------------------------------------------------
// rANS byte encoder assertion macros
// Shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef RANS_BYTE_ENCODER_MACROS_SVH
`define RANS_BYTE_ENCODER_MACROS_SVH

// same-cycle implication
`define RBE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rbe_pkg.sv -----
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared types and constants of the rANS byte encoder.
// ----------------------------------------------------------------------------
package rbe_pkg;

  localparam int unsigned SCALE_W    = 5;
  localparam int unsigned SYM_W      = 17;
  localparam int unsigned STATE_W    = 32;
  localparam logic [STATE_W-1:0] LOWER_BOUND = 32'h0080_0000;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd14;
  localparam logic [SCALE_W-1:0] SCALE_MIN   = 5'd1;
  localparam logic [SCALE_W-1:0] SCALE_MAX   = 5'd16;
  // reciprocal divider: 33 quotient bits, one per step
  localparam int unsigned DIV_STEPS  = 33;
  localparam int unsigned DIV_CNT_W  = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'(DIV_STEPS - 1);

  typedef enum logic [0:0] {
    OP_ENCODE = 1'b0,
    OP_FLUSH  = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_CLAMP,
    DP_PREP,
    DP_RENORM,
    DP_DINIT,
    DP_DIV,
    DP_MUL,
    DP_SHIFT,
    DP_MUL2,
    DP_UPDATE,
    DP_FLUSH
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_PREP,
    ST_RENORM,
    ST_DINIT,
    ST_DIV,
    ST_MUL,
    ST_SHIFT,
    ST_MUL2,
    ST_UPDATE,
    ST_FLUSH
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   emit;   // load one beat into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_flush;
    logic freq_zero;
    logic is_one;
    logic renorm_more;
    logic div_done;
    logic flush_last;
  } dp_sts_t;

endpackage

// ----- rtl/core/rbe_recip.sv -----
// ----------------------------------------------------------------------------
// rbe_recip
// Bit-serial restoring divider for ceil(2^(s+31) / freq), one quotient bit
// per step.
// ----------------------------------------------------------------------------
module rbe_recip (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               init,
  input  logic                               step,
  input  logic [rbe_pkg::SYM_W-1:0]          freq,
  input  logic [rbe_pkg::SCALE_W-1:0]        s,
  output logic [rbe_pkg::STATE_W-1:0]        inv,
  output logic                               done
);

  logic [rbe_pkg::SYM_W-1:0]     rem_r;
  logic [32:0]                   quo_r;
  logic [rbe_pkg::DIV_CNT_W-1:0] cnt_r;

  logic [5:0]               sh;
  logic [47:0]              dvd;
  logic [rbe_pkg::SYM_W-1:0] fm1;
  logic [rbe_pkg::SYM_W:0]  trial;
  logic                     ge;

  // dividend 2^(s+31) + freq - 1; the two terms never overlap
  assign fm1   = freq - 17'd1;
  assign sh    = {1'b0, s} + 6'd31;
  assign dvd   = (48'd1 << sh) | {31'd0, fm1};
  assign trial = {rem_r, quo_r[32]};
  assign ge    = trial >= {1'b0, freq};

  always_ff @(posedge clk) begin
    if (init) begin
      rem_r <= dvd[47:33] == 15'd0 ? '0 : {2'b00, dvd[47:33]};
      quo_r <= dvd[32:0];
    end else if (step) begin
      rem_r <= ge ? 17'(trial - {1'b0, freq}) : trial[16:0];
      quo_r <= {quo_r[31:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (init) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + 6'd1;
    end
  end

  assign done = step && (cnt_r == rbe_pkg::DIV_LAST);
  assign inv  = quo_r[31:0];

endmodule

// ----- rtl/core/rbe_dpath.sv -----
// ----------------------------------------------------------------------------
// rbe_dpath
// Coder state, scale register, symbol clamp, renormalization, reciprocal
// multiply update and the output beat register.
// ----------------------------------------------------------------------------
module rbe_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rbe_pkg::SCALE_W-1:0]   cfg_wdata,
  input  logic                          in_opcode,
  input  logic [rbe_pkg::SYM_W-1:0]     in_sym_start,
  input  logic [rbe_pkg::SYM_W-1:0]     in_sym_freq,
  input  rbe_pkg::dp_cmd_t              cmd,
  output rbe_pkg::dp_sts_t              sts,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [7:0]                    out_byte,
  output logic                          out_last_byte
);

  logic [rbe_pkg::SCALE_W-1:0] scale_r;
  logic [rbe_pkg::STATE_W-1:0] state_r;
  logic                        opcode_r;
  logic [rbe_pkg::SCALE_W-1:0] sc_r;
  logic [rbe_pkg::SYM_W-1:0]   start_r;
  logic [rbe_pkg::SYM_W-1:0]   freq_r;
  logic [rbe_pkg::SYM_W-1:0]   freq_c_r;
  logic [15:0]                 compl_r;
  logic [17:0]                 bias_r;
  logic [rbe_pkg::STATE_W-1:0] ub_r;
  logic [rbe_pkg::SCALE_W-1:0] s_r;
  logic [63:0]                 prod_r;
  logic [rbe_pkg::STATE_W-1:0] q_r;
  logic [rbe_pkg::STATE_W-1:0] p2_r;
  logic [rbe_pkg::STATE_W-1:0] xb_r;
  logic [1:0]                  fl_cnt_r;
  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic                        out_last_r;

  logic [rbe_pkg::SCALE_W-1:0] sc_eff;
  logic [rbe_pkg::SYM_W-1:0]   m;
  logic [rbe_pkg::SYM_W-1:0]   room;
  logic [rbe_pkg::SYM_W-1:0]   fc;
  logic [rbe_pkg::SYM_W-1:0]   diff;
  logic [17:0]                 bias_one;
  logic [rbe_pkg::SYM_W-1:0]   fm1;
  logic [rbe_pkg::SCALE_W-1:0] s_calc;
  logic [rbe_pkg::STATE_W-1:0] shifted;
  logic [rbe_pkg::STATE_W-1:0] inv;
  logic                        div_done;
  logic [47:0]                 m2;
  logic [7:0]                  fl_byte;
  logic [7:0]                  emit_byte;
  logic                        emit_last;
  logic                        out_free;

  always_comb begin
    sc_eff = scale_r;
    if (scale_r < rbe_pkg::SCALE_MIN) sc_eff = rbe_pkg::SCALE_MIN;
    if (scale_r > rbe_pkg::SCALE_MAX) sc_eff = rbe_pkg::SCALE_MAX;
  end

  // clamp freq to the room left above start
  assign m    = 17'd1 << sc_r;
  assign room = m - start_r;
  always_comb begin
    if (start_r > m) fc = '0;
    else if (freq_r > room) fc = room;
    else fc = freq_r;
  end
  assign diff     = m - fc;
  assign bias_one = {1'b0, start_r} + {1'b0, m} - 18'd1;

  // s = ceil(log2 freq)
  assign fm1 = freq_c_r - 17'd1;
  always_comb begin
    s_calc = '0;
    for (int i = 0; i < rbe_pkg::SYM_W; i++) begin
      if (fm1[i]) s_calc = 5'(i + 1);
    end
  end

  assign shifted = {8'd0, state_r[31:8]};
  assign m2      = {16'd0, q_r} * {32'd0, compl_r};

  rbe_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .init  (cmd.op == rbe_pkg::DP_DINIT),
    .step  (cmd.op == rbe_pkg::DP_DIV),
    .freq  (freq_c_r),
    .s     (s_r),
    .inv   (inv),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= rbe_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rbe_pkg::LOWER_BOUND;
      fl_cnt_r <= '0;
    end else begin
      case (cmd.op)
        rbe_pkg::DP_LOAD: begin
          fl_cnt_r <= '0;
        end
        rbe_pkg::DP_RENORM: begin
          state_r <= shifted;
        end
        rbe_pkg::DP_UPDATE: begin
          state_r <= xb_r + p2_r;
        end
        rbe_pkg::DP_FLUSH: begin
          fl_cnt_r <= fl_cnt_r + 2'd1;
          if (fl_cnt_r == 2'd3) state_r <= rbe_pkg::LOWER_BOUND;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rbe_pkg::DP_LOAD: begin
        opcode_r <= in_opcode;
        start_r  <= in_sym_start;
        freq_r   <= in_sym_freq;
        sc_r     <= sc_eff;
      end
      rbe_pkg::DP_CLAMP: begin
        freq_c_r <= fc;
        compl_r  <= diff[15:0];
        bias_r   <= (fc == 17'd1) ? bias_one : {1'b0, start_r};
      end
      rbe_pkg::DP_PREP: begin
        ub_r <= {15'd0, freq_c_r} << (5'd31 - sc_r);
        s_r  <= s_calc;
      end
      rbe_pkg::DP_MUL: begin
        prod_r <= {32'd0, state_r} * {32'd0, inv};
      end
      rbe_pkg::DP_SHIFT: begin
        // freq of one: (x * 0xffffffff) >> 32 is x - 1, or 0 for x == 0
        if (freq_c_r == 17'd1) q_r <= state_r - {31'd0, |state_r};
        else q_r <= prod_r[63:32] >> (s_r - 5'd1);
      end
      rbe_pkg::DP_MUL2: begin
        p2_r <= m2[31:0];
        xb_r <= state_r + {14'd0, bias_r};
      end
      default: begin
      end
    endcase
  end

  // flush goes most significant byte first
  always_comb begin
    case (fl_cnt_r)
      2'd0:    fl_byte = state_r[31:24];
      2'd1:    fl_byte = state_r[23:16];
      2'd2:    fl_byte = state_r[15:8];
      default: fl_byte = state_r[7:0];
    endcase
  end

  always_comb begin
    if (cmd.op == rbe_pkg::DP_FLUSH) begin
      emit_byte = fl_byte;
      emit_last = fl_cnt_r == 2'd3;
    end else begin
      emit_byte = state_r[7:0];
      emit_last = !(shifted > ub_r);
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign sts.out_free    = out_free;
  assign sts.is_flush    = opcode_r == rbe_pkg::OP_FLUSH;
  assign sts.freq_zero   = freq_c_r == '0;
  assign sts.is_one      = freq_c_r == 17'd1;
  assign sts.renorm_more = state_r > ub_r;
  assign sts.div_done    = div_done;
  assign sts.flush_last  = fl_cnt_r == 2'd3;

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule

// ----- rtl/core/rbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbe_ctrl
// Sequencer for one item: clamp, renormalize, divide, multiply, update,
// or the four-beat flush.
// ----------------------------------------------------------------------------
module rbe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rbe_pkg::dp_sts_t sts,
  output rbe_pkg::dp_cmd_t cmd
);

  rbe_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rbe_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rbe_pkg::ST_CLAMP;
      end
      rbe_pkg::ST_CLAMP: begin
        state_nxt = sts.is_flush ? rbe_pkg::ST_FLUSH : rbe_pkg::ST_PREP;
      end
      rbe_pkg::ST_PREP: begin
        state_nxt = sts.freq_zero ? rbe_pkg::ST_IDLE : rbe_pkg::ST_RENORM;
      end
      rbe_pkg::ST_RENORM: begin
        if (!sts.renorm_more) begin
          state_nxt = sts.is_one ? rbe_pkg::ST_SHIFT : rbe_pkg::ST_DINIT;
        end
      end
      rbe_pkg::ST_DINIT:  state_nxt = rbe_pkg::ST_DIV;
      rbe_pkg::ST_DIV: begin
        if (sts.div_done) state_nxt = rbe_pkg::ST_MUL;
      end
      rbe_pkg::ST_MUL:    state_nxt = rbe_pkg::ST_SHIFT;
      rbe_pkg::ST_SHIFT:  state_nxt = rbe_pkg::ST_MUL2;
      rbe_pkg::ST_MUL2:   state_nxt = rbe_pkg::ST_UPDATE;
      rbe_pkg::ST_UPDATE: state_nxt = rbe_pkg::ST_IDLE;
      rbe_pkg::ST_FLUSH: begin
        if (sts.out_free && sts.flush_last) state_nxt = rbe_pkg::ST_IDLE;
      end
      default: state_nxt = rbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '{op: rbe_pkg::DP_NONE, emit: 1'b0};
    in_stall = 1'b1;
    case (state_r)
      rbe_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = rbe_pkg::DP_LOAD;
      end
      rbe_pkg::ST_CLAMP:  cmd.op = rbe_pkg::DP_CLAMP;
      rbe_pkg::ST_PREP:   cmd.op = rbe_pkg::DP_PREP;
      rbe_pkg::ST_RENORM: begin
        if (sts.renorm_more && sts.out_free) begin
          cmd.op   = rbe_pkg::DP_RENORM;
          cmd.emit = 1'b1;
        end
      end
      rbe_pkg::ST_DINIT:  cmd.op = rbe_pkg::DP_DINIT;
      rbe_pkg::ST_DIV:    cmd.op = rbe_pkg::DP_DIV;
      rbe_pkg::ST_MUL:    cmd.op = rbe_pkg::DP_MUL;
      rbe_pkg::ST_SHIFT:  cmd.op = rbe_pkg::DP_SHIFT;
      rbe_pkg::ST_MUL2:   cmd.op = rbe_pkg::DP_MUL2;
      rbe_pkg::ST_UPDATE: cmd.op = rbe_pkg::DP_UPDATE;
      rbe_pkg::ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.op   = rbe_pkg::DP_FLUSH;
          cmd.emit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/rans_byte_encoder.sv -----
// ----------------------------------------------------------------------------
// rans_byte_encoder
// Byte-wise rANS encoder, 32-bit state, reset to 2^23. Feed symbols in
// reverse order; the byte stream read back to front is the compressed data.
// One item at a time. An encode item whose clamped frequency is zero emits
// no bytes; any other encode item emits its renormalization bytes (at most
// two from reachable states) and then updates the state, and all but
// frequency one go through the 33-step bit-serial reciprocal divider. A
// flush emits four output beats. Output stalls hold the block only while a
// beat is waiting. The scale register is sampled when an item is accepted.
// ----------------------------------------------------------------------------
`include "rans_byte_encoder_macros.svh"

module rans_byte_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rbe_pkg::SCALE_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [rbe_pkg::SYM_W-1:0]   in_sym_start,
  input  logic [rbe_pkg::SYM_W-1:0]   in_sym_freq,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_last_byte
);

  rbe_pkg::dp_cmd_t cmd;
  rbe_pkg::dp_sts_t sts;

  rbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rbe_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_opcode     (in_opcode),
    .in_sym_start  (in_sym_start),
    .in_sym_freq   (in_sym_freq),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

  // a new beat never overwrites one still waiting
  `RBE_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, sts.out_free, "beat overwritten")
  `RBE_ASSERT_IMP(a_accept_load, clk, rst_n, in_valid && !in_stall,
                  cmd.op == rbe_pkg::DP_LOAD, "accepted item not loaded")
  `RBE_ASSERT_NXT(a_flush_last, clk, rst_n,
                  cmd.op == rbe_pkg::DP_FLUSH && cmd.emit && sts.flush_last,
                  out_valid && out_last_byte, "flush end not marked")

endmodule

// ----- tb/rans_byte_encoder_checker.sv -----
// ----------------------------------------------------------------------------
// rans_byte_encoder_checker
// Watches the config port and both channels of the rANS byte encoder, keeps
// its own coder state and scale, predicts the bytes for every accepted item
// and compares each output beat against the oldest pending byte.
// ----------------------------------------------------------------------------
module rans_byte_encoder_checker
  import rbe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_opcode,
  input  logic [SYM_W-1:0]   in_sym_start,
  input  logic [SYM_W-1:0]   in_sym_freq,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         out_byte,
  input  logic               out_last_byte,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } enc_byte_t;

  enc_byte_t          expected_bytes[$];
  logic [STATE_W-1:0] coder_state;
  logic [SCALE_W-1:0] scale_q;

  initial begin
    fail_count  = 0;
    pending     = 0;
    coder_state = LOWER_BOUND;
    scale_q     = SCALE_RESET;
  end

  function automatic void rans_encode_item(input opcode_t op, input logic [SYM_W-1:0] start,
                                           input logic [SYM_W-1:0] freq);
    logic [31:0] m, f, st, ub, x, q, bias, compl;
    logic [63:0] inv, prod;
    int unsigned sc, s2;
    if (op == OP_FLUSH) begin
      for (int i = 3; i >= 0; i--)
        expected_bytes.push_back('{coder_state[8*i +: 8], (i == 0)});
      coder_state = LOWER_BOUND;
      return;
    end
    sc = scale_q;
    if (sc < SCALE_MIN) sc = SCALE_MIN;
    if (sc > SCALE_MAX) sc = SCALE_MAX;
    m  = 32'd1 << sc;
    st = 32'(start);
    f  = 32'(freq);
    if (st > m)
      f = 32'd0;
    else if (f > m - st)
      f = m - st;
    if (f == 32'd0)
      return;
    ub = ((LOWER_BOUND >> sc) << 8) * f;
    x  = coder_state;
    // renormalization: the last byte is the one after which the loop stops
    while (x > ub) begin
      expected_bytes.push_back('{x[7:0], ((x >> 8) <= ub)});
      x = x >> 8;
    end
    compl = (m - f) & 32'h0000_ffff;
    if (f == 32'd1) begin
      prod = {32'd0, x} * 64'h0000_0000_ffff_ffff;
      q    = prod[63:32];
      bias = st + m - 32'd1;
    end else begin
      s2 = 0;
      while (f > (32'd1 << s2))
        s2++;
      inv  = ((64'd1 << (s2 + 31)) + 64'(f) - 64'd1) / 64'(f);
      inv  = inv & 64'h0000_0000_ffff_ffff;
      prod = {32'd0, x} * inv;
      q    = prod[63:32] >> (s2 - 1);
      bias = st;
    end
    coder_state = x + bias + q * compl;
  endfunction

  always @(posedge clk) begin
    enc_byte_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      coder_state = LOWER_BOUND;
      scale_q     = SCALE_RESET;
    end else begin
      if (cfg_we)
        scale_q = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected out beat: out_byte=%0h out_last_byte=%0b", out_byte,
                 out_last_byte);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.value) begin
            $error("out_byte mismatch: expected %0h, actual %0h", want.value, out_byte);
            fail_count++;
          end
          if (out_last_byte !== want.last) begin
            $error("out_last_byte mismatch: expected %0b, actual %0b", want.last,
                   out_last_byte);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        rans_encode_item(opcode_t'(in_opcode), in_sym_start, in_sym_freq);
    end
    pending = expected_bytes.size();
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the rANS byte encoder: directed corner items, then
// random symbol streams over several scale settings and idle/stall mixes,
// including one long output hold-off. The checker does all the comparing.
// ----------------------------------------------------------------------------
module tb;
  import rbe_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [SCALE_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_opcode = OP_ENCODE;
  logic [SYM_W-1:0]   in_sym_start = '0;
  logic [SYM_W-1:0]   in_sym_freq = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_byte;
  logic               out_last_byte;
  int                 fail_count;
  int                 pending;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cur_m = 1 << 14;
  int unsigned hold_left = 0;
  bit          hold_armed = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rans_byte_encoder u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_sym_start (in_sym_start),
    .in_sym_freq  (in_sym_freq),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last_byte(out_last_byte)
  );

  rans_byte_encoder_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_sym_start (in_sym_start),
    .in_sym_freq  (in_sym_freq),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last_byte(out_last_byte),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // receiver: random stalls, or one long hold-off when armed
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left  = 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic offer_item(input opcode_t op, input logic [SYM_W-1:0] start,
                            input logic [SYM_W-1:0] freq);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_sym_start <= start;
    in_sym_freq  <= freq;
    do
      @(posedge clk);
    while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_encoder();
    in_valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    // zero-byte items keep the block busy after the last beat
    repeat (80) @(negedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] value);
    int unsigned eff;
    eff = value;
    if (eff < SCALE_MIN) eff = SCALE_MIN;
    if (eff > SCALE_MAX) eff = SCALE_MAX;
    cur_m = 1 << eff;
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_symbol();
    int unsigned r, start, freq, top;
    r     = $urandom_range(99);
    start = $urandom_range(cur_m - 1, 0);
    if (r < 8) begin
      offer_item(OP_FLUSH, SYM_W'($urandom), SYM_W'($urandom));
    end else if (r < 16) begin
      // noise: anything the fields can carry
      offer_item(OP_ENCODE, SYM_W'($urandom_range(17'h1ffff, 0)),
                 SYM_W'($urandom_range(17'h1ffff, 0)));
    end else if (r < 20) begin
      offer_item(OP_ENCODE, SYM_W'(start), '0);
    end else if (r < 35) begin
      offer_item(OP_ENCODE, SYM_W'(start), SYM_W'(1));
    end else begin
      top = cur_m - start;
      if (r < 65 && top > 16)
        top = 16;
      freq = $urandom_range(top, 1);
      offer_item(OP_ENCODE, SYM_W'(start), SYM_W'(freq));
    end
  endtask

  logic [SCALE_W-1:0] phase_scale[8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd9, 5'd14, 5'd5};

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners at reset scale (M = 16384)
    offer_item(OP_ENCODE, 17'd0, 17'd1);
    offer_item(OP_ENCODE, 17'd0, 17'd16384);
    offer_item(OP_ENCODE, 17'd16383, 17'd1);
    offer_item(OP_ENCODE, 17'd16384, 17'd5);
    offer_item(OP_ENCODE, 17'd16385, 17'd3);
    offer_item(OP_ENCODE, 17'h1ffff, 17'h1ffff);
    offer_item(OP_ENCODE, 17'd100, 17'd0);
    offer_item(OP_ENCODE, 17'd16000, 17'd1000);
    offer_item(OP_ENCODE, 17'd3, 17'd2);
    offer_item(OP_ENCODE, 17'd7, 17'd3);
    offer_item(OP_ENCODE, 17'd0, 17'd16383);
    offer_item(OP_ENCODE, 17'd0, 17'd8192);
    offer_item(OP_ENCODE, 17'd5, 17'd1);
    offer_item(OP_ENCODE, 17'd9, 17'd1);
    offer_item(OP_FLUSH, 17'h1ffff, 17'h1ffff);
    offer_item(OP_FLUSH, 17'd0, 17'd0);

    for (int p = 0; p < 8; p++) begin
      drain_encoder();
      write_scale(phase_scale[p]);
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 49;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 49;
        end
        default: begin
          idle_pct = 19;
          stall_pct = 19;
        end
      endcase
      if (p == 0) begin
        offer_item(OP_ENCODE, 17'd65536, 17'd65536);
        offer_item(OP_ENCODE, 17'd0, 17'd65536);
        offer_item(OP_ENCODE, 17'd65535, 17'd1);
      end else if (p == 1) begin
        offer_item(OP_ENCODE, 17'd0, 17'd2);
        offer_item(OP_ENCODE, 17'd1, 17'd1);
        offer_item(OP_ENCODE, 17'd2, 17'd1);
      end else if (p == 5) begin
        hold_armed = 1'b1;
      end
      repeat (20) random_symbol();
    end
    offer_item(OP_FLUSH, 17'd0, 17'd0);
    drain_encoder();

    if (fail_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
